@@ hw/rtl/fmpf_pkg.sv @@
package fmpf_pkg;

	localparam int unsigned SLOT_W  = 7;
	localparam int unsigned INDEX_W = 7;
	localparam int unsigned COUNT_W = 8;
	// wide enough to compare slots and counts against table depths up to 8191
	localparam int unsigned CMP_W   = 13;

	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [7:0] PROTO_TCP = 8'd6;

	typedef enum logic {
		OP_WRITE    = 1'b0,
		OP_CLASSIFY = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_HOLD
	} state_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [SLOT_W-1:0]  rule_slot;
		logic [31:0]        source_address;
		logic [31:0]        dest_address;
		logic [15:0]        source_port;
		logic [15:0]        dest_port;
		logic [7:0]         protocol;
		logic               rule_drops;
	} req_t;

	typedef struct packed {
		logic               verdict;
		logic               hit;
		logic [INDEX_W-1:0] hit_index;
	} rsp_t;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  proto;
		logic        action;
	} rule_t;

endpackage

@@ hw/rtl/fmpf_rule_mem.sv @@
module fmpf_rule_mem #(
	parameter int unsigned MAX_RULES = 128,
	parameter int unsigned AW = 7
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  fmpf_pkg::rule_t       wr_rule,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output fmpf_pkg::rule_t       rd_rule
);

	fmpf_pkg::rule_t mem [MAX_RULES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_rule;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_rule <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/fmpf_search.sv @@
module fmpf_search #(
	parameter int unsigned MAX_RULES = 128,
	parameter int unsigned AW = 7,
	parameter int unsigned CW = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  fmpf_pkg::req_t        req_data,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output fmpf_pkg::rsp_t        rsp_data,
	input  logic [CW-1:0]         limit,
	output logic                  wr_en,
	output logic [AW-1:0]         wr_addr,
	output fmpf_pkg::rule_t       wr_rule,
	output logic                  rd_en,
	output logic [AW-1:0]         rd_addr,
	input  fmpf_pkg::rule_t       rd_rule
);

	fmpf_pkg::state_t state_q, state_d;

	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   limit_q;
	logic            rd_v_s1;
	logic [CW-1:0]   rd_idx_s1;
	fmpf_pkg::req_t  pkt_q;
	fmpf_pkg::req_t  pkt_d;
	fmpf_pkg::rsp_t  res_q;
	fmpf_pkg::rsp_t  rsp_q;
	logic            rsp_valid_q;

	logic accept;
	logic is_write;
	logic slot_ok;
	logic transport;
	logic match;
	logic hit_now;
	logic last_now;
	logic finish;
	logic issue;
	logic out_free;
	logic load_out;

	assign accept    = req_valid && !req_stall;
	assign is_write  = (req_data.opcode == fmpf_pkg::OP_WRITE);
	assign slot_ok   = fmpf_pkg::CMP_W'(req_data.rule_slot) < fmpf_pkg::CMP_W'(MAX_RULES);
	assign transport = (req_data.protocol == fmpf_pkg::PROTO_UDP) ||
	                   (req_data.protocol == fmpf_pkg::PROTO_TCP);

	always_comb begin
		pkt_d = req_data;
		// zero the ports of anything but UDP and TCP
		if (!transport) begin
			pkt_d.source_port = '0;
			pkt_d.dest_port   = '0;
		end
	end

	assign match = ((rd_rule.src_addr == '0) || (rd_rule.src_addr == pkt_q.source_address)) &&
	               ((rd_rule.dst_addr == '0) || (rd_rule.dst_addr == pkt_q.dest_address)) &&
	               ((rd_rule.sport == '0) || (rd_rule.sport == pkt_q.source_port)) &&
	               ((rd_rule.dport == '0) || (rd_rule.dport == pkt_q.dest_port)) &&
	               ((rd_rule.proto == '0) || (rd_rule.proto == pkt_q.protocol));

	assign hit_now  = rd_v_s1 && match;
	assign last_now = rd_v_s1 && !match && ((rd_idx_s1 + CW'(1)) == limit_q);
	assign finish   = (state_q == fmpf_pkg::ST_SEARCH) && (hit_now || last_now);
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fmpf_pkg::ST_IDLE: begin
				if (accept && !is_write) begin
					state_d = (limit == '0) ? fmpf_pkg::ST_HOLD : fmpf_pkg::ST_SEARCH;
				end
			end
			fmpf_pkg::ST_SEARCH: begin
				if (finish) begin
					state_d = fmpf_pkg::ST_HOLD;
				end
			end
			fmpf_pkg::ST_HOLD: begin
				if (out_free) begin
					state_d = fmpf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fmpf_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall = (state_q != fmpf_pkg::ST_IDLE);
		issue     = (state_q == fmpf_pkg::ST_SEARCH) && (cnt_q < limit_q) && !finish;
		load_out  = (state_q == fmpf_pkg::ST_HOLD) && out_free;
		wr_en     = accept && is_write && slot_ok;
	end

	assign rd_en   = issue;
	assign rd_addr = cnt_q[AW-1:0];
	assign wr_addr = AW'(req_data.rule_slot);

	always_comb begin
		wr_rule.src_addr = req_data.source_address;
		wr_rule.dst_addr = req_data.dest_address;
		wr_rule.sport    = req_data.source_port;
		wr_rule.dport    = req_data.dest_port;
		wr_rule.proto    = req_data.protocol;
		wr_rule.action   = req_data.rule_drops;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fmpf_pkg::ST_IDLE;
			rd_v_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (accept) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_idx_s1 <= cnt_q;
		end
		if (accept && !is_write) begin
			limit_q <= limit;
			pkt_q   <= pkt_d;
			res_q   <= '0;
		end else if (finish) begin
			res_q.verdict   <= hit_now ? rd_rule.action : 1'b0;
			res_q.hit       <= hit_now;
			res_q.hit_index <= hit_now ? fmpf_pkg::INDEX_W'(rd_idx_s1) : '0;
		end
		if (load_out) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

@@ hw/rtl/first_match_packet_filter.sv @@
// Rule write: no response; the block stays idle and takes the next request in the next cycle.
// Classify: rules are read one per cycle from the single table read port until the first hit
// or until min(rule_count,MAX_RULES) rules have missed; an empty search reads none. The result
// goes via res_q to the output register; the next request is taken once it is in that register.
// Reset clears control state and rule_count; the rule table is not cleared and holds
// undefined contents until written.
module first_match_packet_filter #(
	parameter int unsigned MAX_RULES = 128
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  fmpf_pkg::req_t                      req_data,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output fmpf_pkg::rsp_t                      rsp_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fmpf_pkg::COUNT_W-1:0]        cfg_data
);

	localparam int unsigned AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int unsigned CW = $clog2(MAX_RULES + 1);

	logic [fmpf_pkg::COUNT_W-1:0] rule_count_q;
	logic [CW-1:0]                limit;

	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	fmpf_pkg::rule_t wr_rule;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	fmpf_pkg::rule_t rd_rule;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			rule_count_q <= cfg_data;
		end
	end

	// saturate the count at the table depth
	assign limit = (fmpf_pkg::CMP_W'(rule_count_q) > fmpf_pkg::CMP_W'(MAX_RULES)) ?
	               CW'(MAX_RULES) : CW'(rule_count_q);

	fmpf_search #(
		.MAX_RULES (MAX_RULES),
		.AW        (AW),
		.CW        (CW)
	) u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.limit     (limit),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_rule   (wr_rule),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_rule   (rd_rule)
	);

	fmpf_rule_mem #(
		.MAX_RULES (MAX_RULES),
		.AW        (AW)
	) u_rule_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_rule (wr_rule),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_rule (rd_rule)
	);

endmodule

@@ verif/testbench.sv @@
module testbench;

	localparam int unsigned TABLE_DEPTH = 128;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned TAIL_CYCLES = 140;
	localparam int unsigned ITEMS_PER_PHASE = 110;

	typedef enum logic {
		STEP_REQUEST,
		STEP_COUNT
	} step_kind_t;

	typedef struct {
		step_kind_t      kind;
		fmpf_pkg::req_t  req;
		logic [7:0]      count;
		logic            typed;
		fmpf_pkg::rsp_t  verdict;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	fmpf_pkg::req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	fmpf_pkg::rsp_t rsp_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [fmpf_pkg::COUNT_W-1:0] cfg_data = '0;

	fmpf_pkg::rule_t rule_mirror [TABLE_DEPTH];
	logic [7:0] count_mirror;
	fmpf_pkg::rsp_t pending_verdicts [$];
	fmpf_pkg::rsp_t want_rsp;
	int unsigned mismatches = 0;
	logic calm = 1'b0;
	int unsigned stall_left = 0;
	step_t directed_steps [$];

	first_match_packet_filter #(
		.MAX_RULES(TABLE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#6000000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic wild_eq(input logic [31:0] rule_val, input logic [31:0] pkt_val);
		return rule_val == 32'd0 || rule_val == pkt_val;
	endfunction

	function automatic fmpf_pkg::rsp_t filter_predict(input fmpf_pkg::req_t pkt);
		fmpf_pkg::rsp_t r;
		int unsigned lim;
		logic [15:0] sp;
		logic [15:0] dp;
		r = '0;
		sp = pkt.source_port;
		dp = pkt.dest_port;
		// ports only mean something for UDP and TCP
		if (pkt.protocol != fmpf_pkg::PROTO_UDP && pkt.protocol != fmpf_pkg::PROTO_TCP) begin
			sp = '0;
			dp = '0;
		end
		lim = (count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : count_mirror;
		for (int unsigned i = 0; i < lim; i++) begin
			if (!r.hit &&
					wild_eq(rule_mirror[i].src_addr, pkt.source_address) &&
					wild_eq(rule_mirror[i].dst_addr, pkt.dest_address) &&
					wild_eq({16'd0, rule_mirror[i].sport}, {16'd0, sp}) &&
					wild_eq({16'd0, rule_mirror[i].dport}, {16'd0, dp}) &&
					wild_eq({24'd0, rule_mirror[i].proto}, {24'd0, pkt.protocol})) begin
				r.verdict = rule_mirror[i].action;
				r.hit = 1'b1;
				r.hit_index = fmpf_pkg::INDEX_W'(i);
			end
		end
		return r;
	endfunction

	function automatic fmpf_pkg::req_t make_request(input fmpf_pkg::opcode_t op,
			input logic [6:0] slot,
			input logic [31:0] sa, input logic [31:0] da, input logic [15:0] sp,
			input logic [15:0] dp, input logic [7:0] pr, input logic drop);
		fmpf_pkg::req_t r;
		r.opcode = op;
		r.rule_slot = slot;
		r.source_address = sa;
		r.dest_address = da;
		r.source_port = sp;
		r.dest_port = dp;
		r.protocol = pr;
		r.rule_drops = drop;
		return r;
	endfunction

	function automatic step_t row_write(input logic [6:0] slot, input logic [31:0] sa,
			input logic [31:0] da, input logic [15:0] sp, input logic [15:0] dp,
			input logic [7:0] pr, input logic drop);
		step_t s;
		s.kind = STEP_REQUEST;
		s.req = make_request(fmpf_pkg::OP_WRITE, slot, sa, da, sp, dp, pr, drop);
		s.count = '0;
		s.typed = 1'b0;
		s.verdict = '0;
		return s;
	endfunction

	// rule_slot and rule_drops are random: a classify must ignore them
	function automatic step_t row_classify(input logic [31:0] sa, input logic [31:0] da,
			input logic [15:0] sp, input logic [15:0] dp, input logic [7:0] pr,
			input logic typed, input fmpf_pkg::rsp_t verdict);
		step_t s;
		s.kind = STEP_REQUEST;
		s.req = make_request(fmpf_pkg::OP_CLASSIFY, 7'($urandom), sa, da, sp, dp, pr,
			1'($urandom));
		s.count = '0;
		s.typed = typed;
		s.verdict = verdict;
		return s;
	endfunction

	function automatic step_t row_count(input logic [7:0] v);
		step_t s;
		s.kind = STEP_COUNT;
		s.req = '0;
		s.count = v;
		s.typed = 1'b0;
		s.verdict = '0;
		return s;
	endfunction

	function automatic logic [31:0] random_rule_field();
		return ($urandom_range(0, 9) < 3) ? 32'd0 : $urandom;
	endfunction

	function automatic logic [7:0] random_proto(input logic allow_wild);
		case ($urandom_range(0, 3))
			0: return allow_wild ? 8'd0 : 8'($urandom);
			1: return fmpf_pkg::PROTO_TCP;
			2: return fmpf_pkg::PROTO_UDP;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic fmpf_pkg::req_t random_rule_write();
		return make_request(fmpf_pkg::OP_WRITE, 7'($urandom), random_rule_field(),
			random_rule_field(), 16'(random_rule_field()), 16'(random_rule_field()),
			random_proto(1'b1), 1'($urandom));
	endfunction

	// mostly packets built from a stored rule, so searches hit at every depth
	function automatic fmpf_pkg::req_t random_packet();
		fmpf_pkg::req_t p;
		fmpf_pkg::rule_t rl;
		int unsigned lim;
		int unsigned bit_pos;
		p = make_request(fmpf_pkg::OP_CLASSIFY, 7'($urandom), $urandom, $urandom,
			16'($urandom), 16'($urandom), random_proto(1'b0), 1'($urandom));
		if ($urandom_range(0, 9) < 7) begin
			lim = (count_mirror == 0) ? TABLE_DEPTH :
				((count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : count_mirror);
			rl = rule_mirror[$urandom_range(0, lim - 1)];
			if (rl.src_addr != 0) p.source_address = rl.src_addr;
			if (rl.dst_addr != 0) p.dest_address = rl.dst_addr;
			if (rl.sport != 0) p.source_port = rl.sport;
			if (rl.dport != 0) p.dest_port = rl.dport;
			if (rl.proto != 0) p.protocol = rl.proto;
			if ($urandom_range(0, 4) == 0) begin
				bit_pos = $urandom_range(0, 31);
				case ($urandom_range(0, 4))
					0: p.source_address[bit_pos] = ~p.source_address[bit_pos];
					1: p.dest_address[bit_pos] = ~p.dest_address[bit_pos];
					2: p.source_port[bit_pos % 16] = ~p.source_port[bit_pos % 16];
					3: p.dest_port[bit_pos % 16] = ~p.dest_port[bit_pos % 16];
					default: p.protocol[bit_pos % 8] = ~p.protocol[bit_pos % 8];
				endcase
			end
		end
		return p;
	endfunction

	task automatic send_request(input fmpf_pkg::req_t r, input logic typed,
			input fmpf_pkg::rsp_t typed_rsp);
		int unsigned gap;
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do @(posedge clk); while (req_stall);
		if (r.opcode == fmpf_pkg::OP_CLASSIFY) begin
			pending_verdicts.push_back(typed ? typed_rsp : filter_predict(r));
		end else begin
			rule_mirror[r.rule_slot] = '{r.source_address, r.dest_address, r.source_port,
				r.dest_port, r.protocol, r.rule_drops};
		end
	endtask

	// hold requests until every response is back and the block has settled
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [7:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		count_mirror = v;
	endtask

	always @(posedge clk) begin
		if (!arst_n || calm) begin
			rsp_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left != 0) begin
			rsp_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			rsp_stall <= 1'b1;
			stall_left = $urandom_range(0, 7);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_verdicts.size() == 0) begin
				$error("response with no request waiting: %p", rsp_data);
				mismatches++;
			end else begin
				want_rsp = pending_verdicts.pop_front();
				if (rsp_data.verdict !== want_rsp.verdict) begin
					$error("verdict: expected %0d, actual %0d", want_rsp.verdict,
						rsp_data.verdict);
					mismatches++;
				end
				if (rsp_data.hit !== want_rsp.hit) begin
					$error("hit: expected %0d, actual %0d", want_rsp.hit, rsp_data.hit);
					mismatches++;
				end
				if (rsp_data.hit_index !== want_rsp.hit_index) begin
					$error("hit_index: expected %0d, actual %0d", want_rsp.hit_index,
						rsp_data.hit_index);
					mismatches++;
				end
			end
		end
	end

	initial begin
		logic [7:0] phase_counts [12];
		phase_counts = '{8'd0, 8'd1, 8'd128, 8'd255, 8'd3, 8'd200, 8'd16, 8'd127, 8'd64,
			8'd7, 8'd129, 8'd40};
		count_mirror = '0;
		foreach (rule_mirror[k]) rule_mirror[k] = '0;

		// empty table after reset
		directed_steps.push_back(row_classify('1, '1, '1, '1, 8'hFF, 1'b1, '{1'b0, 1'b0, 7'd0}));
		directed_steps.push_back(row_write(7'd0, '1, '1, '1, '1, fmpf_pkg::PROTO_TCP, 1'b1));
		directed_steps.push_back(row_write(7'd1, 32'h0A00_0001, '0, '0, '0, 8'd0, 1'b0));
		directed_steps.push_back(row_write(7'd2, '0, 32'hC0A8_0001, '0, 16'd80, 8'd0, 1'b1));
		// ICMP rule with ports stored: never matches a packet
		directed_steps.push_back(row_write(7'd3, '0, '0, 16'd1234, '0, 8'd1, 1'b1));
		directed_steps.push_back(row_write(7'd4, '0, '0, '0, '0, 8'd0, 1'b0));
		directed_steps.push_back(row_count(8'd1));
		directed_steps.push_back(row_classify('1, '1, '1, '1, fmpf_pkg::PROTO_TCP, 1'b1,
			'{1'b1, 1'b1, 7'd0}));
		directed_steps.push_back(row_classify('0, '0, '0, '0, 8'd0, 1'b1, '{1'b0, 1'b0, 7'd0}));
		directed_steps.push_back(row_count(8'd5));
		directed_steps.push_back(row_classify(32'h0A00_0001, 32'h1234_5678, 16'd1, 16'd2,
			fmpf_pkg::PROTO_UDP, 1'b1, '{1'b0, 1'b1, 7'd1}));
		directed_steps.push_back(row_classify(32'h0A00_0002, 32'hC0A8_0001, 16'd9, 16'd80,
			fmpf_pkg::PROTO_UDP, 1'b1, '{1'b1, 1'b1, 7'd2}));
		// destination rule value placed in the source address
		directed_steps.push_back(row_classify(32'hC0A8_0001, 32'h0A0A_0A0A, 16'd0, 16'd80,
			fmpf_pkg::PROTO_TCP, 1'b0, '0));
		// non-transport protocol zeroes the packet ports
		directed_steps.push_back(row_classify(32'h0A00_0002, 32'hC0A8_0001, 16'd9, 16'd80,
			8'd1, 1'b0, '0));
		directed_steps.push_back(row_classify('0, '0, 16'd1234, '1, 8'd1, 1'b0, '0));
		directed_steps.push_back(row_classify('1, '1, '1, '1, fmpf_pkg::PROTO_UDP, 1'b0, '0));
		directed_steps.push_back(row_classify('1, '0, '1, '0, 8'hFF, 1'b0, '0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[k]) begin
			if (directed_steps[k].kind == STEP_COUNT)
				write_count(directed_steps[k].count);
			else
				send_request(directed_steps[k].req, directed_steps[k].typed,
					directed_steps[k].verdict);
		end

		// fill the rest of the table before any wider search
		for (int unsigned s = 5; s < TABLE_DEPTH; s++) begin
			send_request(make_request(fmpf_pkg::OP_WRITE, 7'(s), random_rule_field(),
				random_rule_field(), 16'(random_rule_field()), 16'(random_rule_field()),
				random_proto(1'b1), 1'($urandom)), 1'b0, '0);
		end

		foreach (phase_counts[ph]) begin
			write_count(phase_counts[ph]);
			calm = (ph == $size(phase_counts) - 1) || ($urandom_range(0, 3) == 0);
			for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 99) == 0)
					wait_idle();
				if ($urandom_range(0, 3) == 0)
					send_request(random_rule_write(), 1'b0, '0);
				else
					send_request(random_packet(), 1'b0, '0);
			end
		end

		req_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_verdicts.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ first_match_packet_filter.f @@
hw/rtl/fmpf_pkg.sv
hw/rtl/fmpf_rule_mem.sv
hw/rtl/fmpf_search.sv
hw/rtl/first_match_packet_filter.sv
verif/testbench.sv
